>>> rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg: shared types and constants for the saturating interval ALU
// Holds the operation codes, the int32 limits and the payload structs that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package sia_pkg;

   // Operation codes. The unused codes 6 and 7 behave as a move.
   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_INC  = 3'd3;
   localparam logic [2:0] CMD_DEC  = 3'd4;
   localparam logic [2:0] CMD_MOVE = 3'd5;

   // Limits of a signed 32-bit bound.
   localparam logic signed [31:0] LIM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] LIM_MIN = 32'sh8000_0000;

   // Stage 1 result: linear bounds and the four corner products.
   typedef struct packed {
      logic               is_mul;
      logic signed [32:0] lin_lo;
      logic signed [32:0] lin_hi;
      logic signed [63:0] p0;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] p3;
   } prod_type;

   // Stage 2 result: pairwise minimum and maximum of the products.
   typedef struct packed {
      logic               is_mul;
      logic signed [32:0] lin_lo;
      logic signed [32:0] lin_hi;
      logic signed [63:0] min_a;
      logic signed [63:0] max_a;
      logic signed [63:0] min_b;
      logic signed [63:0] max_b;
   } pair_type;

   // Stage 3 result: exact bounds before saturation.
   typedef struct packed {
      logic signed [63:0] lo;
      logic signed [63:0] hi;
   } exact_type;

   // Stage 4 result: saturated bounds and the overflow flag.
   typedef struct packed {
      logic               overflow;
      logic signed [31:0] res_high;
      logic signed [31:0] res_low;
   } result_type;

endpackage

>>> rtl/sia_prod.sv
// ----------------------------------------------------------------------------
// sia_prod: operand stage
// Forms the add, sub, inc, dec and move bounds at 33 bits and the four
// signed 32x32 corner products, one multiplier per corner.
// ----------------------------------------------------------------------------
module sia_prod
   import sia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [2:0]         cmd,
   input  logic signed [31:0] a_low,
   input  logic signed [31:0] a_high,
   input  logic signed [31:0] b_low,
   input  logic signed [31:0] b_high,
   output logic               out_valid,
   input  logic               out_ready,
   output prod_type           out_data
);

   logic               valid_ff;
   logic               valid_in;
   prod_type           data_ff;
   prod_type           data_in;
   logic signed [32:0] al;
   logic signed [32:0] ah;
   logic signed [32:0] bl;
   logic signed [32:0] bh;

   // The stage takes a new request when it is empty or drains this cycle.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign al = {a_low[31], a_low};
   assign ah = {a_high[31], a_high};
   assign bl = {b_low[31], b_low};
   assign bh = {b_high[31], b_high};

   // Linear bounds by operation, products for the multiply path.
   always_comb begin
      data_in        = '0;
      data_in.is_mul = (cmd == CMD_MUL);
      data_in.p0     = 64'(a_low) * 64'(b_low);
      data_in.p1     = 64'(a_low) * 64'(b_high);
      data_in.p2     = 64'(a_high) * 64'(b_low);
      data_in.p3     = 64'(a_high) * 64'(b_high);
      unique case (cmd)
         CMD_ADD: begin
            data_in.lin_lo = al + bl;
            data_in.lin_hi = ah + bh;
         end
         CMD_SUB: begin
            data_in.lin_lo = al - bh;
            data_in.lin_hi = ah - bl;
         end
         CMD_INC: begin
            data_in.lin_lo = al + 33'sd1;
            data_in.lin_hi = ah + 33'sd1;
         end
         CMD_DEC: begin
            data_in.lin_lo = al - 33'sd1;
            data_in.lin_hi = ah - 33'sd1;
         end
         default: begin
            data_in.lin_lo = al;
            data_in.lin_hi = ah;
         end
      endcase
   end

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register loads only on an accepted request.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/sia_minmax.sv
// ----------------------------------------------------------------------------
// sia_minmax: pairwise compare stage
// Reduces the four corner products to the minimum and maximum of each pair.
// ----------------------------------------------------------------------------
module sia_minmax
   import sia_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pair_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   pair_type data_ff;
   pair_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // First level of the min and max trees; the linear bounds pass along.
   always_comb begin
      data_in.is_mul = in_data.is_mul;
      data_in.lin_lo = in_data.lin_lo;
      data_in.lin_hi = in_data.lin_hi;
      data_in.min_a  = (in_data.p0 < in_data.p1) ? in_data.p0 : in_data.p1;
      data_in.max_a  = (in_data.p0 > in_data.p1) ? in_data.p0 : in_data.p1;
      data_in.min_b  = (in_data.p2 < in_data.p3) ? in_data.p2 : in_data.p3;
      data_in.max_b  = (in_data.p2 > in_data.p3) ? in_data.p2 : in_data.p3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/sia_select.sv
// ----------------------------------------------------------------------------
// sia_select: bound select stage
// Finishes the min and max trees and picks the exact bounds of the result,
// either from the products or from the sign-extended linear bounds.
// ----------------------------------------------------------------------------
module sia_select
   import sia_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pair_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output exact_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   exact_type data_ff;
   exact_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Final compare for multiply, widening for the other operations.
   always_comb begin
      if (in_data.is_mul) begin
         data_in.lo = (in_data.min_a < in_data.min_b) ? in_data.min_a : in_data.min_b;
         data_in.hi = (in_data.max_a > in_data.max_b) ? in_data.max_a : in_data.max_b;
      end else begin
         data_in.lo = {{31{in_data.lin_lo[32]}}, in_data.lin_lo};
         data_in.hi = {{31{in_data.lin_hi[32]}}, in_data.lin_hi};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/sia_sat.sv
// ----------------------------------------------------------------------------
// sia_sat: saturation stage and output register
// Clamps each exact bound to the int32 range and raises the overflow flag
// when either bound is clamped.
// ----------------------------------------------------------------------------
module sia_sat
   import sia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  exact_type  in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic               valid_ff;
   logic               valid_in;
   result_type         data_ff;
   result_type         data_in;
   logic signed [63:0] lim_max_w;
   logic signed [63:0] lim_min_w;
   logic               lo_above;
   logic               lo_below;
   logic               hi_above;
   logic               hi_below;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign lim_max_w = 64'(LIM_MAX);
   assign lim_min_w = 64'(LIM_MIN);

   // Range checks on both bounds.
   assign lo_above = (in_data.lo > lim_max_w);
   assign lo_below = (in_data.lo < lim_min_w);
   assign hi_above = (in_data.hi > lim_max_w);
   assign hi_below = (in_data.hi < lim_min_w);

   // Clamp and flag.
   always_comb begin
      data_in.overflow = lo_above || lo_below || hi_above || hi_below;
      if (lo_above) begin
         data_in.res_low = LIM_MAX;
      end else if (lo_below) begin
         data_in.res_low = LIM_MIN;
      end else begin
         data_in.res_low = in_data.lo[31:0];
      end
      if (hi_above) begin
         data_in.res_high = LIM_MAX;
      end else if (hi_below) begin
         data_in.res_high = LIM_MIN;
      end else begin
         data_in.res_high = in_data.hi[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/saturating_interval_alu_top.sv
// ----------------------------------------------------------------------------
// saturating_interval_alu_top: saturating interval ALU for int32 intervals
// An accepted request passes one stage each for the corner multipliers, the
// pairwise compare, the final compare with bound select, and the saturation
// into the output register. Throughput is one request per cycle while
// rsp_tready is high; every stage has its own valid bit and takes a request
// whenever it is empty or drains in the same cycle.
// Synchronous reset clears the valid bits only; payload registers keep data.
// ----------------------------------------------------------------------------
module saturating_interval_alu_top
   import sia_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: cmd[2:0], a_low[34:3], a_high[66:35],
   // b_low[98:67], b_high[130:99], zero fill[135:131].
   input  logic [135:0] req_tdata,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: res_low[31:0], res_high[63:32], overflow[64],
   // zero fill[71:65].
   output logic [71:0]  rsp_tdata
);

   logic       s1_valid;
   logic       s1_ready;
   prod_type   s1_data;
   logic       s2_valid;
   logic       s2_ready;
   pair_type   s2_data;
   logic       s3_valid;
   logic       s3_ready;
   exact_type  s3_data;
   result_type res;

   // Stage 1: linear bounds and corner products.
   sia_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .cmd       (req_tdata[2:0]),
      .a_low     ($signed(req_tdata[34:3])),
      .a_high    ($signed(req_tdata[66:35])),
      .b_low     ($signed(req_tdata[98:67])),
      .b_high    ($signed(req_tdata[130:99])),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // Stage 2: pairwise minimum and maximum.
   sia_minmax u_minmax (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // Stage 3: exact bound select.
   sia_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // Stage 4: saturation into the output register.
   sia_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // Pack the result fields.
   assign rsp_tdata = {7'd0, res.overflow, res.res_high, res.res_low};

   // An empty output register means the whole pipeline can take a request.
   a_ready_when_drained: assert property (
      @(posedge clock) disable iff (reset)
      !rsp_tvalid |-> (req_tready && s1_ready && s2_ready && s3_ready)
   ) else $error("pipeline stalls with an empty output register");

   // A raised overflow flag goes with at least one bound at a limit.
   a_overflow_at_limit: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && res.overflow) |->
         (res.res_low == LIM_MAX || res.res_low == LIM_MIN ||
          res.res_high == LIM_MAX || res.res_high == LIM_MIN)
   ) else $error("overflow flagged without a clamped bound");

   // Reset leaves no result in any stage.
   a_reset_empties: assert property (
      @(posedge clock)
      reset |=> (!rsp_tvalid && !s1_valid && !s2_valid && !s3_valid)
   ) else $error("stage valid after reset");

endmodule
